@@ hdl/irctok_pkg.sv @@
// ----------------------------------------------------------------------------
// irctok_pkg
// Shared codes, state record and keyword tables for the IRC line tokenizer.
// ----------------------------------------------------------------------------
package irctok_pkg;

  // Argument limit and field widths
  localparam int unsigned MaxArgs   = 15;
  localparam int unsigned ArgIdxW   = 4;
  localparam int unsigned KindW     = 3;
  localparam int unsigned ClassW    = 3;
  localparam int unsigned PhaseW    = 3;
  localparam int unsigned CmdLenW   = 3;
  localparam int unsigned NumKw     = 5;
  localparam int unsigned KwMaskW   = 6;

  // Characters of interest
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChColon = 8'd58;
  localparam logic [7:0] ChZero  = 8'd48;
  localparam logic [7:0] ChNine  = 8'd57;

  // Parse phase codes
  localparam logic [PhaseW-1:0] PhStart   = 3'd0;
  localparam logic [PhaseW-1:0] PhPrefix  = 3'd1;
  localparam logic [PhaseW-1:0] PhCommand = 3'd2;
  localparam logic [PhaseW-1:0] PhArgs    = 3'd3;
  localparam logic [PhaseW-1:0] PhTrail   = 3'd4;
  localparam logic [PhaseW-1:0] PhDiscard = 3'd5;

  // Field kind codes
  localparam logic [KindW-1:0] KindPrefix  = 3'd0;
  localparam logic [KindW-1:0] KindCommand = 3'd1;
  localparam logic [KindW-1:0] KindArg     = 3'd2;
  localparam logic [KindW-1:0] KindTrail   = 3'd3;
  localparam logic [KindW-1:0] KindDelim   = 3'd4;
  localparam logic [KindW-1:0] KindDiscard = 3'd5;
  localparam logic [KindW-1:0] KindEnd     = 3'd6;

  // Command class codes
  localparam logic [ClassW-1:0] ClsNone    = 3'd0;
  localparam logic [ClassW-1:0] ClsNumeric = 3'd1;
  localparam logic [ClassW-1:0] ClsPing    = 3'd2;
  localparam logic [ClassW-1:0] ClsMessage = 3'd3;
  localparam logic [ClassW-1:0] ClsError   = 3'd4;
  localparam logic [ClassW-1:0] ClsJoin    = 3'd5;
  localparam logic [ClassW-1:0] ClsOther   = 3'd6;

  // Keyword slots
  localparam logic [2:0] KwPing    = 3'd0;
  localparam logic [2:0] KwNotice  = 3'd1;
  localparam logic [2:0] KwPrivmsg = 3'd2;
  localparam logic [2:0] KwError   = 3'd3;
  localparam logic [2:0] KwJoin    = 3'd4;

  // Tokenizer state carried between bytes
  typedef struct packed {
    logic [PhaseW-1:0]  phase;
    logic [CmdLenW-1:0] cmd_len;
    logic [KwMaskW-1:0] kw_match;
    logic               all_digits;
    logic [ArgIdxW-1:0] arg_idx;
    logic [ClassW-1:0]  class_held;
    logic               at_tok;
  } state_t;

  localparam state_t StateInit = '{
    phase:      PhStart,
    cmd_len:    '0,
    kw_match:   '1,
    all_digits: 1'b1,
    arg_idx:    '0,
    class_held: ClsNone,
    at_tok:     1'b1
  };

  // Per-byte tags
  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [ArgIdxW-1:0] idx;
    logic               tstart;
    logic [ClassW-1:0]  cls;
    logic               cvalid;
    logic [ArgIdxW-1:0] count;
    logic               lend;
  } result_t;

  // Keyword length
  function automatic logic [CmdLenW-1:0] kw_len(input logic [2:0] k);
    logic [CmdLenW-1:0] len;
    case (k)
      KwPing:    len = 3'd4;
      KwNotice:  len = 3'd6;
      KwPrivmsg: len = 3'd7;
      KwError:   len = 3'd5;
      KwJoin:    len = 3'd4;
      default:   len = 3'd0;
    endcase
    return len;
  endfunction

  // Keyword character at a position (text left aligned in 7 bytes)
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
    logic [55:0] txt;
    logic [5:0]  sh;
    case (k)
      KwPing:    txt = {"PING", 24'h0};
      KwNotice:  txt = {"NOTICE", 8'h0};
      KwPrivmsg: txt = "PRIVMSG";
      KwError:   txt = {"ERROR", 16'h0};
      KwJoin:    txt = {"JOIN", 24'h0};
      default:   txt = '0;
    endcase
    sh = 6'(8 * (6 - 32'(pos)));
    return txt[sh +: 8];
  endfunction

endpackage

@@ hdl/irctok_step.sv @@
// ----------------------------------------------------------------------------
// irctok_step
// Next-state and tag logic for one byte of the line.
// ----------------------------------------------------------------------------
module irctok_step import irctok_pkg::*; (
  input  state_t     st_i,
  input  logic [7:0] byte_i,
  output state_t     st_o,
  output result_t    res_o
);

  // Class from the command seen so far
  function automatic logic [ClassW-1:0] classify(input state_t s);
    logic [NumKw-1:0] hit;
    logic [ClassW-1:0] c;
    for (int k = 0; k < NumKw; k++) begin
      hit[k] = s.kw_match[k] && (s.cmd_len >= kw_len(3'(k)));
    end
    if (s.cmd_len <= 3'd3 && s.all_digits) c = ClsNumeric;
    else if (hit[KwPing]) c = ClsPing;
    else if (hit[KwNotice] || hit[KwPrivmsg]) c = ClsMessage;
    else if (hit[KwError]) c = ClsError;
    else if (hit[KwJoin]) c = ClsJoin;
    else c = ClsOther;
    return c;
  endfunction

  logic       is_cmd;
  logic       cmd_tok;
  logic [4:0] idx_next;

  assign idx_next = {1'b0, st_i.arg_idx} + 5'd1;

  always_comb begin
    st_o   = st_i;
    res_o  = '0;
    res_o.kind = KindDelim;
    is_cmd  = 1'b0;
    cmd_tok = st_i.at_tok;

    if (byte_i == ChCr) begin
      // Line end: report and return to line start
      res_o.kind   = KindEnd;
      res_o.lend   = 1'b1;
      res_o.cvalid = 1'b1;
      res_o.cls    = st_i.class_held;
      case (st_i.phase)
        PhStart, PhCommand: res_o.cls = classify(st_i);
        PhPrefix:           res_o.cls = ClsNone;
        PhArgs, PhTrail:    res_o.count = idx_next[ArgIdxW-1:0];
        default:            res_o.count = ArgIdxW'(MaxArgs);
      endcase
      st_o = StateInit;
    end else begin
      case (st_i.phase)
        PhStart: begin
          if (byte_i == ChColon) begin
            st_o.phase  = PhPrefix;
            st_o.at_tok = 1'b1;
          end else begin
            is_cmd  = 1'b1;
            cmd_tok = 1'b1;
          end
        end
        PhCommand: is_cmd = 1'b1;
        PhPrefix: begin
          if (byte_i == ChSpace) begin
            st_o.phase  = PhCommand;
            st_o.at_tok = 1'b1;
          end else begin
            res_o.kind   = KindPrefix;
            res_o.tstart = st_i.at_tok;
            st_o.at_tok  = 1'b0;
          end
        end
        PhArgs: begin
          res_o.idx = st_i.arg_idx;
          if (byte_i == ChSpace) begin
            if (idx_next < 5'(MaxArgs)) begin
              st_o.arg_idx = idx_next[ArgIdxW-1:0];
              res_o.idx    = idx_next[ArgIdxW-1:0];
              st_o.at_tok  = 1'b1;
            end else begin
              // argument limit reached: drop the rest of the line
              res_o.idx  = '0;
              st_o.phase = PhDiscard;
            end
          end else if (byte_i == ChColon && st_i.at_tok) begin
            st_o.phase = PhTrail;
          end else begin
            res_o.kind   = KindArg;
            res_o.tstart = st_i.at_tok;
            st_o.at_tok  = 1'b0;
          end
        end
        PhTrail: begin
          res_o.idx    = st_i.arg_idx;
          res_o.kind   = KindTrail;
          res_o.tstart = st_i.at_tok;
          st_o.at_tok  = 1'b0;
        end
        default: res_o.kind = KindDiscard;
      endcase

      // Command bytes: space closes the command, others feed the matchers
      if (is_cmd) begin
        if (byte_i == ChSpace) begin
          st_o.class_held = classify(st_i);
          res_o.cvalid    = 1'b1;
          st_o.phase      = PhArgs;
          st_o.arg_idx    = '0;
          st_o.at_tok     = 1'b1;
        end else begin
          st_o.phase   = PhCommand;
          res_o.kind   = KindCommand;
          res_o.tstart = cmd_tok;
          st_o.at_tok  = 1'b0;
          for (int k = 0; k < NumKw; k++) begin
            if (st_i.cmd_len < kw_len(3'(k)) &&
                kw_char(3'(k), st_i.cmd_len) != byte_i) begin
              st_o.kw_match[k] = 1'b0;
            end
          end
          if (st_i.cmd_len != 3'd7) st_o.cmd_len = st_i.cmd_len + 3'd1;
          if (byte_i < ChZero || byte_i > ChNine) st_o.all_digits = 1'b0;
        end
      end
      res_o.cls = st_o.class_held;
    end
  end

endmodule

@@ hdl/irc_line_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// irc_line_tokenizer_top
// Byte-serial IRC line tokenizer: tags each byte and classes the command.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------
//  in       | sink      | in_valid_i / in_ready_o    | data_byte_i
//  out      | source    | out_valid_o / out_ready_i  | data_byte_out_o .. line_end_o
//
//  One byte per cycle while no held result blocks the input; its tags appear in the
//  output register the cycle after the transfer. The state update and tagging is one
//  pass of logic. Reset returns the parser to line start and empties the output
//  register. A held result blocks input only if out_ready_i is low in that cycle.
// ----------------------------------------------------------------------------
module irc_line_tokenizer_top import irctok_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         data_byte_out_o,
  output logic [KindW-1:0]   field_kind_o,
  output logic [ArgIdxW-1:0] arg_index_o,
  output logic               token_start_o,
  output logic [ClassW-1:0]  command_class_o,
  output logic               class_valid_o,
  output logic [ArgIdxW-1:0] arg_count_o,
  output logic               line_end_o
);

  state_t     st_q, st_d;
  result_t    res_d, res_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  logic       in_xfer;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  irctok_step u_step (
    .st_i   (st_q),
    .byte_i (data_byte_i),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateInit;
    end else if (in_xfer) begin
      st_q <= st_d;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q <= data_byte_i;
      res_q  <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign data_byte_out_o = byte_q;
  assign field_kind_o    = res_q.kind;
  assign arg_index_o     = res_q.idx;
  assign token_start_o   = res_q.tstart;
  assign command_class_o = res_q.cls;
  assign class_valid_o   = res_q.cvalid;
  assign arg_count_o     = res_q.count;
  assign line_end_o      = res_q.lend;

  // Checks
  a_cr_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && data_byte_i == ChCr |=> st_q == StateInit)
    else $error("state not back at line start after carriage return");

  a_xfer_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_q)
    else $error("accepted byte produced no result");

  a_count_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && arg_count_o != '0 |-> line_end_o && class_valid_o)
    else $error("argument count outside line end");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == PhArgs |-> 32'(st_q.arg_idx) < MaxArgs)
    else $error("argument index beyond limit");

endmodule

@@ sim/tb_irc_line_tokenizer_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_irc_line_tokenizer_top
// Self-checking bench for the IRC line tokenizer. Byte streams (edge lines,
// random well-formed lines, raw noise) go in through the input channel while
// a parser model in the bench tags every accepted byte; each tagged byte out
// of the block is compared field by field with the oldest prediction. Both
// channels idle in random bursts, and one long output hold fills the block.
// ----------------------------------------------------------------------------
module tb_irc_line_tokenizer_top;
  import irctok_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 64;
  localparam int unsigned MaxReports = 20;

  // Tags of one byte as the block should emit them
  typedef struct packed {
    logic [7:0]         data;
    logic [KindW-1:0]   kind;
    logic [ArgIdxW-1:0] idx;
    logic               tstart;
    logic [ClassW-1:0]  cls;
    logic               cvalid;
    logic [ArgIdxW-1:0] count;
    logic               lend;
  } byte_tag_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [7:0]         data_byte_i = 8'h00;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [7:0]         data_byte_out_o;
  logic [KindW-1:0]   field_kind_o;
  logic [ArgIdxW-1:0] arg_index_o;
  logic               token_start_o;
  logic [ClassW-1:0]  command_class_o;
  logic               class_valid_o;
  logic [ArgIdxW-1:0] arg_count_o;
  logic               line_end_o;

  byte_tag_t   expected_tags[$];
  logic [7:0]  line_buf[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned hold_left      = 0;
  int unsigned stall_left     = 0;
  bit          idle_on        = 1'b0;

  // Parser state of the bench model
  logic [PhaseW-1:0]  p_phase;
  logic [CmdLenW-1:0] p_cmd_len;
  logic [KwMaskW-1:0] p_kw;
  logic               p_digits;
  logic [ArgIdxW-1:0] p_arg;
  logic [ClassW-1:0]  p_cls;
  logic               p_at_tok;

  string kw_word[NumKw] = '{"PING", "NOTICE", "PRIVMSG", "ERROR", "JOIN"};

  irc_line_tokenizer_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .data_byte_out_o (data_byte_out_o),
    .field_kind_o    (field_kind_o),
    .arg_index_o     (arg_index_o),
    .token_start_o   (token_start_o),
    .command_class_o (command_class_o),
    .class_valid_o   (class_valid_o),
    .arg_count_o     (arg_count_o),
    .line_end_o      (line_end_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  function automatic void clear_line_state();
    p_phase   = PhStart;
    p_cmd_len = '0;
    p_kw      = '1;
    p_digits  = 1'b1;
    p_arg     = '0;
    p_cls     = ClsNone;
    p_at_tok  = 1'b1;
  endfunction

  function automatic bit kw_seen(int k);
    return p_kw[k] && (int'(p_cmd_len) >= kw_word[k].len());
  endfunction

  function automatic logic [ClassW-1:0] command_class();
    if (p_cmd_len <= 3 && p_digits) return ClsNumeric;
    if (kw_seen(KwPing)) return ClsPing;
    if (kw_seen(KwNotice) || kw_seen(KwPrivmsg)) return ClsMessage;
    if (kw_seen(KwError)) return ClsError;
    if (kw_seen(KwJoin)) return ClsJoin;
    return ClsOther;
  endfunction

  // Narrow the keyword candidates and track length and digit-only
  function automatic void absorb_command_char(logic [7:0] c);
    int pos;
    int k;
    pos = int'(p_cmd_len);
    for (k = 0; k < NumKw; k++) begin
      if (pos < kw_word[k].len() && kw_word[k][pos] != c) p_kw[k] = 1'b0;
    end
    if (p_cmd_len < 7) p_cmd_len = p_cmd_len + 1'b1;
    if (c < ChZero || c > ChNine) p_digits = 1'b0;
  endfunction

  function automatic byte_tag_t tag_byte(logic [7:0] c);
    byte_tag_t t;
    t      = '0;
    t.data = c;
    t.kind = KindDelim;
    if (c == ChCr) begin
      t.kind   = KindEnd;
      t.lend   = 1'b1;
      t.cvalid = 1'b1;
      case (p_phase)
        PhStart, PhCommand: p_cls = command_class();
        PhPrefix:           p_cls = ClsNone;
        PhArgs, PhTrail:    t.count = p_arg + 1'b1;
        default:            t.count = ArgIdxW'(MaxArgs);
      endcase
      t.cls = p_cls;
      clear_line_state();
    end else begin
      // anything but a colon at line start opens the command
      if (p_phase == PhStart && c != ChColon) begin
        p_phase  = PhCommand;
        p_at_tok = 1'b1;
      end
      case (p_phase)
        PhStart: begin
          p_phase  = PhPrefix;
          p_at_tok = 1'b1;
        end
        PhCommand: begin
          if (c == ChSpace) begin
            p_cls    = command_class();
            t.cvalid = 1'b1;
            p_phase  = PhArgs;
            p_arg    = '0;
            p_at_tok = 1'b1;
          end else begin
            t.kind   = KindCommand;
            t.tstart = p_at_tok;
            p_at_tok = 1'b0;
            absorb_command_char(c);
          end
        end
        PhPrefix: begin
          if (c == ChSpace) begin
            p_phase  = PhCommand;
            p_at_tok = 1'b1;
          end else begin
            t.kind   = KindPrefix;
            t.tstart = p_at_tok;
            p_at_tok = 1'b0;
          end
        end
        PhArgs: begin
          t.idx = p_arg;
          if (c == ChSpace) begin
            if (int'(p_arg) + 1 < MaxArgs) begin
              p_arg    = p_arg + 1'b1;
              t.idx    = p_arg;
              p_at_tok = 1'b1;
            end else begin
              // argument limit reached: rest of line is dropped
              t.idx   = '0;
              p_phase = PhDiscard;
            end
          end else if (c == ChColon && p_at_tok) begin
            p_phase = PhTrail;
          end else begin
            t.kind   = KindArg;
            t.tstart = p_at_tok;
            p_at_tok = 1'b0;
          end
        end
        PhTrail: begin
          t.idx    = p_arg;
          t.kind   = KindTrail;
          t.tstart = p_at_tok;
          p_at_tok = 1'b0;
        end
        default: t.kind = KindDiscard;
      endcase
      t.cls = p_cls;
    end
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    if (mismatch_count < MaxReports) $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want,
                             logic [7:0] data);
    if (got != want)
      report_mismatch($sformatf("%s got %0d want %0d (byte 0x%02h)", name, got, want, data));
  endtask

  always @(posedge clk_i) begin
    byte_tag_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_tags.size() == 0) begin
        report_mismatch($sformatf("result 0x%02h with nothing pending", data_byte_out_o));
      end else begin
        want = expected_tags.pop_front();
        check_field("data_byte_out", data_byte_out_o, want.data, want.data);
        check_field("field_kind", field_kind_o, want.kind, want.data);
        check_field("arg_index", arg_index_o, want.idx, want.data);
        check_field("token_start", token_start_o, want.tstart, want.data);
        check_field("command_class", command_class_o, want.cls, want.data);
        check_field("class_valid", class_valid_o, want.cvalid, want.data);
        check_field("arg_count", arg_count_o, want.count, want.data);
        check_field("line_end", line_end_o, want.lend, want.data);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t watchdog: no transfer, %0d results pending", $time,
                 expected_tags.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // Receiver: long hold on request, otherwise short random stalls while idle_on is set
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0)
          stall_left = $urandom_range(1, 4);
        if (stall_left != 0) begin
          out_ready_i = 1'b0;
          stall_left--;
        end else begin
          out_ready_i = 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] c);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    data_byte_i = c;
    do @(posedge clk_i); while (!in_ready_o);
    expected_tags.push_back(tag_byte(c));
  endtask

  task automatic send_line_buf();
    foreach (line_buf[i]) send_byte(line_buf[i]);
  endtask

  // Sender pauses until every predicted byte has come out
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_tags.size() != 0) @(posedge clk_i);
  endtask

  function automatic void push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  // Ordinary character: never CR, space or colon
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 7) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(33, 126));
    end while (c == ChCr || c == ChSpace || c == ChColon);
    return c;
  endfunction

  function automatic void push_command();
    int k;
    int pos;
    int i;
    k = $urandom_range(0, NumKw - 1);
    case ($urandom_range(0, 9))
      0, 1, 2: push_text(kw_word[k]);
      3: begin
        // keyword with extra characters still matches
        push_text(kw_word[k]);
        repeat ($urandom_range(1, 3)) line_buf.push_back(plain_char());
      end
      4: push_text(kw_word[k].substr(0, $urandom_range(0, kw_word[k].len() - 2)));
      5, 6: repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(48, 57)));
      7: repeat ($urandom_range(4, 7)) line_buf.push_back(8'($urandom_range(48, 57)));
      8: begin
        // one letter of a keyword replaced by a random capital, which may not differ
        pos = $urandom_range(0, kw_word[k].len() - 1);
        for (i = 0; i < kw_word[k].len(); i++)
          line_buf.push_back(i == pos ? 8'($urandom_range(65, 90)) : kw_word[k][i]);
      end
      default: repeat ($urandom_range(0, 9)) line_buf.push_back(plain_char());
    endcase
  endfunction

  // Well-formed line with random content
  function automatic void build_line();
    int nargs;
    int a;
    line_buf.delete();
    if ($urandom_range(0, 2) == 0) begin
      line_buf.push_back(ChColon);
      repeat ($urandom_range(0, 5))
        line_buf.push_back($urandom_range(0, 5) == 0 ? ChColon : plain_char());
      if ($urandom_range(0, 9) != 0) line_buf.push_back(ChSpace);
    end
    push_command();
    nargs = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 18) : $urandom_range(0, 5);
    for (a = 0; a < nargs; a++) begin
      line_buf.push_back(ChSpace);
      if (a == nargs - 1 && $urandom_range(0, 2) == 0) begin
        line_buf.push_back(ChColon);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 3) == 0)
            line_buf.push_back($urandom_range(0, 1) ? ChSpace : ChColon);
          else
            line_buf.push_back(plain_char());
        end
      end else begin
        repeat ($urandom_range(0, 4))
          line_buf.push_back($urandom_range(0, 7) == 0 ? ChColon : plain_char());
      end
    end
    line_buf.push_back(ChCr);
  endfunction

  task automatic send_random_lines(int unsigned n_bytes);
    int unsigned sent;
    sent = 0;
    while (sent < n_bytes) begin
      build_line();
      send_line_buf();
      sent += line_buf.size();
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Empty line, prefix-only line, odd bytes in trailing text, empty args, odd-byte command
  task automatic test_edge_lines();
    idle_on = 1'b0;
    line_buf.delete();
    line_buf.push_back(ChCr);
    push_text(":x");
    line_buf.push_back(ChCr);
    push_text("9 :");
    line_buf.push_back(8'h00);
    line_buf.push_back(ChSpace);
    line_buf.push_back(8'h0A);
    line_buf.push_back(8'hFF);
    line_buf.push_back(ChCr);
    push_text("PING  ");
    line_buf.push_back(ChCr);
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h00);
    line_buf.push_back(ChCr);
    send_line_buf();
    wait_for_results();
  endtask

  task automatic test_random_lines();
    idle_on = 1'b1;
    send_random_lines(600);
  endtask

  // Output held off long enough that the block backs up into the input
  task automatic test_output_hold();
    hold_left = HoldCycles;
    send_random_lines(40);
    wait_for_results();
  endtask

  // Unstructured bytes, biased toward the delimiters
  task automatic test_noise_bytes();
    idle_on = 1'b1;
    repeat (200) begin
      case ($urandom_range(0, 7))
        0:       send_byte(ChCr);
        1:       send_byte(ChSpace);
        2:       send_byte(ChColon);
        default: send_byte(8'($urandom_range(0, 255)));
      endcase
    end
    send_byte(ChCr);
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    send_random_lines(150);
  endtask

  initial begin
    clear_line_state();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_edge_lines();
    test_random_lines();
    test_output_hold();
    test_noise_bytes();
    test_steady_stream();
    wait_for_results();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/irctok_pkg.sv
hdl/irctok_step.sv
hdl/irc_line_tokenizer_top.sv
sim/tb_irc_line_tokenizer_top.sv
